// ===== sv/block_decomposed_range_sum_assert.svh =====
// assertion macros shared by the range sum block
`ifndef BLOCK_DECOMPOSED_RANGE_SUM_ASSERT_SVH
`define BLOCK_DECOMPOSED_RANGE_SUM_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BDRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BDRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bdrs_pkg.sv =====
// types and constants of the block decomposed range sum
`default_nettype none

package bdrs_pkg;

    localparam int CNT_W  = 11;
    localparam int POS_W  = 10;
    localparam int VAL_W  = 16;
    localparam int SUM_W  = 26;
    localparam int BS_W   = 6;
    localparam int SQ_W   = 12;
    localparam int ODD_W  = 8;
    localparam int DCNT_W = 4;
    localparam int REQ_W  = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_IGNORE = 2'd3;

    localparam logic REG_ELEMENT_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQRT,
        ST_DISPATCH,
        ST_DIV,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_Q_HEAD,
        ST_Q_BLOCKS,
        ST_Q_TAIL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr;
        logic take;
        logic sqrt_step;
        logic derive;
        logic set_err;
        logic div_start;
        logic div_step;
        logic upd_rd;
        logic upd_wr;
        logic head_step;
        logic blk_step;
        logic tail_step;
        logic post;
    } cmd_t;

    typedef struct packed {
        logic             in_ignore;
        logic             derived;
        logic             sqrt_done;
        logic             clr_last;
        logic [REQ_W-1:0] kind;
        logic             load_full;
        logic             pos_bad;
        logic             right_bad;
        logic             empty;
        logic             div_last;
        logic             head_go;
        logic             blk_go;
        logic             tail_go;
        logic             out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/bdrs_ctrl.sv =====
// controller state machine of the range sum block
`default_nettype none
`include "block_decomposed_range_sum_assert.svh"

module bdrs_ctrl
    import bdrs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   disp_err;
    logic   disp_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        disp_err = 1'b0;
        disp_go  = 1'b0;
        case (st.kind)
            REQ_LOAD: begin
                disp_err = st.load_full;
                disp_go  = !st.load_full;
            end
            REQ_UPDATE: begin
                disp_err = st.pos_bad;
                disp_go  = !st.pos_bad;
            end
            REQ_QUERY: begin
                disp_err = st.pos_bad || st.right_bad;
                disp_go  = !(st.pos_bad || st.right_bad) && !st.empty;
            end
            default: begin
                disp_err = 1'b0;
                disp_go  = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (st.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid && !st.in_ignore) begin
                    state_next = st.derived ? ST_DISPATCH : ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (st.sqrt_done) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                state_next = disp_go ? ST_DIV : ST_FINISH;
            end
            ST_DIV: begin
                if (st.div_last) begin
                    state_next = (st.kind == REQ_QUERY) ? ST_Q_HEAD : ST_UPD_RD;
                end
            end
            ST_UPD_RD: begin
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                state_next = ST_FINISH;
            end
            ST_Q_HEAD: begin
                if (!st.head_go) state_next = ST_Q_BLOCKS;
            end
            ST_Q_BLOCKS: begin
                if (!st.blk_go) state_next = ST_Q_TAIL;
            end
            ST_Q_TAIL: begin
                if (!st.tail_go) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (st.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_SQRT: begin
                cmd.sqrt_step = !st.sqrt_done;
                cmd.derive    = st.sqrt_done;
            end
            ST_DISPATCH: begin
                cmd.set_err   = disp_err;
                cmd.div_start = disp_go;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_UPD_RD: begin
                cmd.upd_rd = 1'b1;
            end
            ST_UPD_WR: begin
                cmd.upd_wr = 1'b1;
            end
            ST_Q_HEAD: begin
                cmd.head_step = st.head_go;
            end
            ST_Q_BLOCKS: begin
                cmd.blk_step = st.blk_go;
            end
            ST_Q_TAIL: begin
                cmd.tail_step = st.tail_go;
            end
            ST_FINISH: begin
                cmd.post = st.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    `BDRS_ASSERT_IMP(a_post_free, cmd.post, st.out_free, "result register overwritten")
    `BDRS_ASSERT_NXT(a_div_len, (state_reg == ST_DIV) && !st.div_last, state_reg == ST_DIV,
        "division left early")
    `BDRS_ASSERT_IMP(a_derived_kept, 1'b1, !$fell(st.derived), "block size lost")
    `BDRS_ASSERT_IMP(a_div_derived, cmd.div_start, st.derived, "division without block size")

endmodule

`default_nettype wire

// ===== sv/bdrs_datapath.sv =====
// datapath of the range sum block: stores, root, divider and accumulator
`default_nettype none

module bdrs_datapath
    import bdrs_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int MAX_BLOCKS   = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [39:0]      s_tdata,
    input  wire logic [REQ_W-1:0] s_tuser,
    output logic [31:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [CNT_W-1:0] cfg_count,
    input  wire cmd_t             cmd,
    output status_t               st
);

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int BLK_W  = $clog2(MAX_BLOCKS);
    localparam int CLR_N  = (MAX_ELEMENTS > MAX_BLOCKS) ? MAX_ELEMENTS : MAX_BLOCKS;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int CLAMP  = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;
    localparam int EXT_W  = CNT_W + 1;

    logic [REQ_W-1:0] kind_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] right_reg;
    logic [VAL_W-1:0] val_reg;
    logic             err_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] lc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [BS_W-1:0]  root_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [ODD_W-1:0] odd_reg;
    logic             derived_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] dvd_reg;
    logic [CNT_W-1:0] q_reg;
    logic [BS_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [CLR_W-1:0] clr_reg;
    logic             acc_elem_reg;
    logic             acc_blk_reg;
    logic [VAL_W-1:0] elem_rdata_reg;
    logic [SUM_W-1:0] blk_rdata_reg;
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic             out_err_reg;

    logic [VAL_W-1:0] elem_mem [MAX_ELEMENTS];
    logic [SUM_W-1:0] blk_mem  [MAX_BLOCKS];

    logic [CNT_W-1:0]  n_clamp;
    logic [CNT_W-1:0]  sel_idx;
    logic [CNT_W-1:0]  right_ext;
    logic [BS_W:0]     trial;
    logic [BS_W:0]     trial_sub;
    logic              trial_ge;
    logic [BLK_W-1:0]  blk_addr;
    logic              elem_we;
    logic [ADDR_W-1:0] elem_waddr;
    logic [VAL_W-1:0]  elem_wdata;
    logic              elem_re;
    logic              blk_we;
    logic [BLK_W-1:0]  blk_waddr;
    logic [SUM_W-1:0]  blk_wdata;
    logic              blk_re;
    logic [SUM_W-1:0]  val_ext;
    logic [SUM_W-1:0]  old_ext;
    logic [SUM_W-1:0]  rd_ext;

    always_comb begin
        if (cfg_count == '0) begin
            n_clamp = CNT_W'(1);
        end else if (cfg_count > CNT_W'(CLAMP)) begin
            n_clamp = CNT_W'(CLAMP);
        end else begin
            n_clamp = cfg_count;
        end
    end

    assign right_ext = CNT_W'(right_reg);
    assign sel_idx   = (kind_reg == REQ_LOAD) ? lc_reg : CNT_W'(pos_reg);
    assign trial     = {rem_reg, dvd_reg[CNT_W-1]};
    assign trial_sub = trial - {1'b0, root_reg};
    assign trial_ge  = trial >= {1'b0, root_reg};
    assign blk_addr  = (q_reg > CNT_W'(MAX_BLOCKS - 1)) ? BLK_W'(MAX_BLOCKS - 1)
                                                       : q_reg[BLK_W-1:0];

    assign val_ext = {{(SUM_W-VAL_W){val_reg[VAL_W-1]}}, val_reg};
    assign old_ext = {{(SUM_W-VAL_W){elem_rdata_reg[VAL_W-1]}}, elem_rdata_reg};
    assign rd_ext  = acc_elem_reg ? old_ext : '0;

    // memory ports
    assign elem_we    = (cmd.clr && (int'(clr_reg) < MAX_ELEMENTS)) || cmd.upd_wr;
    assign elem_waddr = cmd.clr ? ADDR_W'(clr_reg) : ADDR_W'(idx_reg);
    assign elem_wdata = cmd.clr ? '0 : val_reg;
    assign elem_re    = cmd.upd_rd || cmd.head_step || cmd.tail_step;
    assign blk_we     = (cmd.clr && (int'(clr_reg) < MAX_BLOCKS)) || cmd.upd_wr;
    assign blk_waddr  = cmd.clr ? BLK_W'(clr_reg) : blk_addr;
    assign blk_wdata  = cmd.clr ? '0 : (blk_rdata_reg + val_ext - old_ext);
    assign blk_re     = cmd.upd_rd || cmd.blk_step;

    always_ff @(posedge aclk) begin
        if (elem_we) elem_mem[elem_waddr] <= elem_wdata;
        if (elem_re) elem_rdata_reg <= elem_mem[ADDR_W'(idx_reg)];
    end

    always_ff @(posedge aclk) begin
        if (blk_we) blk_mem[blk_waddr] <= blk_wdata;
        if (blk_re) blk_rdata_reg <= blk_mem[blk_addr];
    end

    always_comb begin
        sum_next = sum_reg + rd_ext + (acc_blk_reg ? blk_rdata_reg : '0);
        if (cmd.take) sum_next = '0;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            derived_reg   <= 1'b0;
            lc_reg        <= '0;
            acc_elem_reg  <= 1'b0;
            acc_blk_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr) clr_reg <= clr_reg + CLR_W'(1);
            if (cmd.derive) derived_reg <= 1'b1;
            if (cmd.upd_wr && (kind_reg == REQ_LOAD)) lc_reg <= lc_reg + CNT_W'(1);
            acc_elem_reg <= cmd.head_step || cmd.tail_step;
            acc_blk_reg  <= cmd.blk_step;
            if (cmd.post) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item, root, divider and walk registers
    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (cmd.take) begin
            kind_reg  <= s_tuser;
            pos_reg   <= s_tdata[9:0];
            right_reg <= s_tdata[19:10];
            val_reg   <= s_tdata[35:20];
            err_reg   <= 1'b0;
            if (!derived_reg) begin
                cnt_reg  <= n_clamp;
                root_reg <= '0;
                sq_reg   <= SQ_W'(1);
                odd_reg  <= ODD_W'(3);
            end
        end
        if (cmd.set_err) err_reg <= 1'b1;
        if (cmd.sqrt_step) begin
            root_reg <= root_reg + BS_W'(1);
            sq_reg   <= sq_reg + SQ_W'(odd_reg);
            odd_reg  <= odd_reg + ODD_W'(2);
        end
        if (cmd.div_start) begin
            idx_reg  <= sel_idx;
            dvd_reg  <= sel_idx;
            q_reg    <= '0;
            rem_reg  <= '0;
            dcnt_reg <= DCNT_W'(CNT_W - 1);
        end
        if (cmd.div_step) begin
            rem_reg  <= trial_ge ? trial_sub[BS_W-1:0] : trial[BS_W-1:0];
            q_reg    <= {q_reg[CNT_W-2:0], trial_ge};
            dvd_reg  <= {dvd_reg[CNT_W-2:0], 1'b0};
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
        if (cmd.head_step) begin
            idx_reg <= idx_reg + CNT_W'(1);
            if ((rem_reg + BS_W'(1)) == root_reg) begin
                rem_reg <= '0;
                q_reg   <= q_reg + CNT_W'(1);
            end else begin
                rem_reg <= rem_reg + BS_W'(1);
            end
        end
        if (cmd.blk_step) begin
            idx_reg <= idx_reg + CNT_W'(root_reg);
            q_reg   <= q_reg + CNT_W'(1);
        end
        if (cmd.tail_step) idx_reg <= idx_reg + CNT_W'(1);
        if (cmd.post) begin
            out_sum_reg <= err_reg ? '0 : sum_reg;
            out_err_reg <= err_reg;
        end
    end

    always_comb begin
        st.in_ignore = (s_tuser == REQ_IGNORE);
        st.derived   = derived_reg;
        st.sqrt_done = sq_reg > SQ_W'(cnt_reg);
        st.clr_last  = (clr_reg == CLR_W'(CLR_N - 1));
        st.kind      = kind_reg;
        st.load_full = lc_reg >= cnt_reg;
        st.pos_bad   = CNT_W'(pos_reg) >= cnt_reg;
        st.right_bad = right_ext >= cnt_reg;
        st.empty     = pos_reg > right_reg;
        st.div_last  = (dcnt_reg == '0);
        st.head_go   = (idx_reg < right_ext) && (rem_reg != '0);
        st.blk_go    = (EXT_W'(idx_reg) + EXT_W'(root_reg)) <= EXT_W'(right_reg);
        st.tail_go   = idx_reg <= right_ext;
        st.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32-SUM_W){1'b0}}, out_sum_reg};
    assign m_tuser  = out_err_reg;

endmodule

`default_nettype wire

// ===== sv/block_decomposed_range_sum.sv =====
// top level of the block decomposed range sum
// load or update: divide, read, write, post; next item taken in the cycle after the post
// query: divide, then add head elements, whole blocks and tail elements in that order
// the walk reads one element or block sum a cycle from the stores
// first item after reset runs a square root search to find the block size
// reset: stores cleared over max(MAX_ELEMENTS, MAX_BLOCKS) entries, no input taken
`default_nettype none

module block_decomposed_range_sum
    import bdrs_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int MAX_BLOCKS   = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [39:0]      s_tdata,  // position, right_end, value
    input  wire logic [REQ_W-1:0] s_tuser,  // req_type
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,  // range_sum
    output logic                  m_tuser,  // status
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [CNT_W-1:0] element_count_reg;
    cmd_t             cmd;
    status_t          st;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= CNT_W'(1024);
        end else if (psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT)) begin
            element_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? {{(32-CNT_W){1'b0}}, element_count_reg}
                                                    : '0;

    bdrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bdrs_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_count (element_count_reg),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the block decomposed range sum
`timescale 1ns / 100ps

module testbench;
    import bdrs_pkg::*;

    localparam int MAX_ELEM     = 1024;
    localparam int MAX_BLK      = 64;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE       = 200;
    localparam int PHASE_ITEMS  = 460;
    localparam int N_ROWS       = 20;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             status;
    } sum_result_t;

    typedef struct {
        logic [REQ_W-1:0] kind;
        int               pos;
        int               rgt;
        int               val;
        bit               typed;
        int               sum;
        bit               status;
    } stim_row_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata  = '0;  // position, right_end, value
    logic [REQ_W-1:0] s_tuser  = '0;  // req_type
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [31:0]      m_tdata;        // range_sum
    logic             m_tuser;        // status
    logic             psel     = 1'b0;
    logic             penable  = 1'b0;
    logic             pwrite   = 1'b0;
    logic [2:0]       paddr    = '0;
    logic [31:0]      pwdata   = '0;
    logic [31:0]      prdata;
    logic             pready;

    block_decomposed_range_sum DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shadow of the block state
    logic [CNT_W-1:0]        count_reg = 11'd1024;
    logic signed [VAL_W-1:0] elem_shadow [MAX_ELEM];
    longint                  block_totals [MAX_BLK];
    int                      next_load  = 0;
    int                      block_len  = 0;
    int                      live_count = 0;

    sum_result_t pending_sums [$];

    int src_idle   = 0;
    int dst_idle   = 0;
    int errors     = 0;
    int n_items    = 0;
    int n_queries  = 0;
    int n_flagged  = 0;
    int n_compared = 0;
    int cycle_cnt  = 0;

    stim_row_t dir_rows [N_ROWS] = '{
        '{REQ_QUERY,     0,    0,      0, 1,      0, 0},
        '{REQ_IGNORE, 1023, 1023,     -1, 0,      0, 0},
        '{REQ_LOAD,   1023, 1023, -32768, 1,      0, 0},
        '{REQ_QUERY,     0,    0,      0, 1, -32768, 0},
        '{REQ_LOAD,      0,    0,  32767, 1,      0, 0},
        '{REQ_QUERY,     0,    1,      0, 1,     -1, 0},
        '{REQ_UPDATE,    0,    0,  32767, 1,      0, 0},
        '{REQ_QUERY,     0,    1,      0, 1,  65534, 0},
        '{REQ_QUERY,     1,    0,      0, 1,      0, 0},
        '{REQ_UPDATE, 1023,    0,    100, 0,      0, 0},
        '{REQ_QUERY,     0, 1023,      0, 0,      0, 0},
        '{REQ_QUERY,  1023, 1023,      0, 0,      0, 0},
        '{REQ_UPDATE,  682,    0,  21845, 0,      0, 0},
        '{REQ_UPDATE,  341,    0, -21846, 0,      0, 0},
        '{REQ_LOAD,      0,    0,  21845, 0,      0, 0},
        '{REQ_LOAD,      0,    0, -21846, 0,      0, 0},
        '{REQ_QUERY,     0,    3,      0, 0,      0, 0},
        '{REQ_QUERY,     2,  682,      0, 0,      0, 0},
        '{REQ_QUERY,     1,    1,      0, 0,      0, 0},
        '{REQ_QUERY,     0, 1022,      0, 0,      0, 0}
    };

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle);
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic int block_index(input int idx);
        int b;
        b = idx / block_len;
        if (b >= MAX_BLK) b = MAX_BLK - 1;
        return b;
    endfunction

    function automatic void store_element(input int idx, input logic signed [VAL_W-1:0] val);
        block_totals[block_index(idx)] += longint'(val) - longint'(elem_shadow[idx]);
        elem_shadow[idx] = val;
    endfunction

    // returns 1 when the request produces a result
    function automatic bit predict_request(
        input  logic [REQ_W-1:0]        kind,
        input  logic [POS_W-1:0]        pos,
        input  logic [POS_W-1:0]        rgt,
        input  logic signed [VAL_W-1:0] val,
        output sum_result_t             res
    );
        longint acc;
        int     l;
        int     r;
        acc = 0;
        res = '0;
        if (kind == REQ_IGNORE) return 1'b0;
        if (block_len == 0) begin
            live_count = (count_reg == 0) ? 1 : ((count_reg > MAX_ELEM) ? MAX_ELEM : count_reg);
            while ((block_len + 1) * (block_len + 1) <= live_count) block_len++;
        end
        l = pos;
        r = rgt;
        case (kind)
            REQ_LOAD: begin
                if (next_load >= live_count) begin
                    res.status = 1'b1;
                end else begin
                    store_element(next_load, val);
                    next_load++;
                end
            end
            REQ_UPDATE: begin
                if (l >= live_count) res.status = 1'b1;
                else store_element(l, val);
            end
            default: begin
                if (l >= live_count || r >= live_count) begin
                    res.status = 1'b1;
                end else if (l <= r) begin
                    while (l < r && (l % block_len) != 0) begin
                        acc += elem_shadow[l];
                        l++;
                    end
                    while (l + block_len <= r) begin
                        acc += block_totals[block_index(l)];
                        l += block_len;
                    end
                    while (l <= r) begin
                        acc += elem_shadow[l];
                        l++;
                    end
                end
            end
        endcase
        res.sum = acc[SUM_W-1:0];
        return 1'b1;
    endfunction

    // called and left at a falling edge
    task automatic send_item(
        input logic [REQ_W-1:0] kind,
        input int               pos,
        input int               rgt,
        input int               val,
        input bit               typed,
        input int               tsum,
        input bit               tstatus
    );
        sum_result_t res;
        logic [VAL_W-1:0] v16;
        v16 = val[VAL_W-1:0];
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, v16, rgt[POS_W-1:0], pos[POS_W-1:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_request(kind, pos[POS_W-1:0], rgt[POS_W-1:0], v16, res)) begin
            if (typed) res = '{sum: tsum[SUM_W-1:0], status: tstatus};
            pending_sums.push_back(res);
            n_items++;
            if (kind == REQ_QUERY) n_queries++;
            if (res.status) n_flagged++;
        end
        @(negedge aclk);
    endtask

    task automatic send_random_request();
        logic [REQ_W-1:0] kind;
        int p;
        int r;
        int v;
        int roll;
        p = $urandom_range(0, 1023);
        r = $urandom_range(0, 1023);
        roll = $urandom_range(0, 9);
        case (roll)
            0: v = -32768;
            1: v = 32767;
            2: v = -1;
            3: v = 0;
            default: v = $signed(16'($urandom_range(0, 65535)));
        endcase
        roll = $urandom_range(0, 99);
        if (next_load < live_count && roll < 80) kind = REQ_LOAD;
        else if (roll < 84) kind = REQ_IGNORE;
        else if (roll < 90 || (next_load >= live_count && roll < 94)) kind = REQ_LOAD;
        else if ($urandom_range(0, 1) == 0) kind = REQ_UPDATE;
        else kind = REQ_QUERY;
        if (kind == REQ_UPDATE && $urandom_range(0, 9) != 0) begin
            p = $urandom_range(0, live_count - 1);
        end
        if (kind == REQ_QUERY) begin
            roll = $urandom_range(0, 19);
            if (roll == 1) begin
                p = $urandom_range(1, live_count - 1);
                r = $urandom_range(0, p - 1);
            end else if (roll == 2) begin
                p = 0;
                r = live_count - 1;
            end else if (roll > 2) begin
                p = $urandom_range(0, live_count - 1);
                r = $urandom_range(p, live_count - 1);
            end
        end
        send_item(kind, p, r, v, 1'b0, 0, 1'b0);
    endtask

    // called and left at a falling edge
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_count(input int value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_ELEMENT_COUNT, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        count_reg = value[CNT_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    always @(posedge aclk) begin
        sum_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sums.size() == 0) begin
                $error("unexpected result transfer: range_sum %0d status %0d",
                       $signed(m_tdata[SUM_W-1:0]), m_tuser);
                errors++;
            end else begin
                want = pending_sums.pop_front();
                n_compared++;
                if (m_tdata[SUM_W-1:0] !== want.sum) begin
                    $error("range_sum mismatch: expected %0d, actual %0d",
                           $signed(want.sum), $signed(m_tdata[SUM_W-1:0]));
                    errors++;
                end
                if (m_tuser !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        int chosen;
        int target;
        for (int i = 0; i < MAX_ELEM; i++) elem_shadow[i] = '0;
        for (int i = 0; i < MAX_BLK; i++) block_totals[i] = 0;
        case ($urandom_range(0, 5))
            0: chosen = 2047;
            1: chosen = 1024;
            default: chosen = $urandom_range(2, 300);
        endcase
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_count(2047);
        if (chosen != 2047) write_count(chosen);

        src_idle = 13;
        dst_idle = 48;
        for (int i = 0; i < N_ROWS; i++) begin
            send_item(dir_rows[i].kind, dir_rows[i].pos, dir_rows[i].rgt, dir_rows[i].val,
                      dir_rows[i].typed, dir_rows[i].sum, dir_rows[i].status);
        end

        for (int ph = 0; ph < 3; ph++) begin
            if (ph > 0) begin
                drain_results();
                repeat (SETTLE) @(negedge aclk);
                // count is latched at the first request, later writes must not matter
                write_count(ph == 1 ? 0 : 1);
                src_idle = (ph == 1) ? 48 : 0;
                dst_idle = (ph == 1) ? 13 : 0;
            end
            target = n_items + PHASE_ITEMS / 2;
            while (n_items < target) send_random_request();
            drain_results();
            target = n_items + PHASE_ITEMS / 2;
            while (n_items < target) send_random_request();
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (pending_sums.size() != 0) begin
            $error("%0d expected results never arrived", pending_sums.size());
            errors++;
        end
        $display("covered %0d requests (%0d queries, %0d flagged) over %0d elements, block size %0d",
                 n_items, n_queries, n_flagged, live_count, block_len);
        $display("%0d results compared, %0d mismatches", n_compared, errors);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
